### hdl/c_subset_token_scanner_top_defines.svh
// Assertion macros for the C subset token scanner checker.
// Included by the checker file only; depends on nothing else.
`ifndef C_SUBSET_TOKEN_SCANNER_TOP_DEFINES_SVH
`define C_SUBSET_TOKEN_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define CST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define CST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define CST_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/cst_pkg.sv
// Shared types, codes and keyword table of the C subset token scanner.
// No dependencies; the interface, core, queue, top and checker files import it.
package cst_pkg;

   // Fixed widths of the result fields.
   localparam int KIND_W = 3;
   localparam int CODE_W = 5;
   localparam int ERR_W  = 2;
   localparam int SPAN_W = 24;
   localparam int LINE_W = 20;
   localparam int COL_W  = 16;

   // Keyword storage: eight characters, the length counts up to nine for long names.
   localparam int KEYWORD_CHARS = 8;
   localparam int NAME_W        = 8 * KEYWORD_CHARS;
   localparam int LEN_W         = $clog2(KEYWORD_CHARS + 2);
   localparam int KW_COUNT      = 10;

   // Result queue depth; must be a power of two and at least two.
   localparam int QUEUE_DEPTH = 4;

   localparam logic [KIND_W-1:0] KIND_EOF     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WORD    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_IDENT   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_STRING  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_INVALID = 3'd4;

   localparam logic [CODE_W-1:0] CODE_NONE   = 5'd0;
   localparam logic [CODE_W-1:0] CODE_LPAREN = 5'd11;
   localparam logic [CODE_W-1:0] CODE_RPAREN = 5'd12;
   localparam logic [CODE_W-1:0] CODE_LBRACE = 5'd13;
   localparam logic [CODE_W-1:0] CODE_RBRACE = 5'd14;
   localparam logic [CODE_W-1:0] CODE_STAR   = 5'd15;
   localparam logic [CODE_W-1:0] CODE_SEMI   = 5'd16;
   localparam logic [CODE_W-1:0] CODE_COMMA  = 5'd17;
   localparam logic [CODE_W-1:0] CODE_DOT1   = 5'd18;
   localparam logic [CODE_W-1:0] CODE_DOT2   = 5'd19;
   localparam logic [CODE_W-1:0] CODE_DOT3   = 5'd20;

   localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_UNTERM     = 2'd1;
   localparam logic [ERR_W-1:0] ERR_NEWLINE    = 2'd2;
   localparam logic [ERR_W-1:0] ERR_UNEXPECTED = 2'd3;

   // Names are shifted in at the low byte, so the first character sits highest,
   // which is the layout of a right-aligned string literal.
   localparam logic [NAME_W-1:0] KW_TEXT [KW_COUNT] = '{
      "void", "char", "short", "int", "long",
      "signed", "unsigned", "const", "volatile", "extern"
   };
   localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
      4'd4, 4'd4, 4'd5, 4'd3, 4'd4, 4'd6, 4'd8, 4'd5, 4'd8, 4'd6
   };

   typedef struct packed {
      logic [KIND_W-1:0] token_kind;
      logic [CODE_W-1:0] word_code;
      logic [ERR_W-1:0]  error_code;
      logic [SPAN_W-1:0] span_start;
      logic [SPAN_W-1:0] span_end;
      logic [LINE_W-1:0] first_line_no;
      logic [COL_W-1:0]  first_col_no;
      logic [LINE_W-1:0] last_line_no;
      logic [COL_W-1:0]  last_col_no;
      logic              run_last;
   } rsp_type;

   // Up to two results from one input transfer, in emission order.
   typedef struct packed {
      logic    first_valid;
      logic    second_valid;
      rsp_type first;
      rsp_type second;
   } push_type;

   // Returns the keyword code 1..10, or none.
   function automatic logic [CODE_W-1:0] keyword_code(input logic [NAME_W-1:0] chars,
                                                      input logic [LEN_W-1:0] len);
      logic [CODE_W-1:0] code;
      code = CODE_NONE;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (len == KW_LEN[k] && chars == KW_TEXT[k]) begin
            code = CODE_W'(k + 1);
         end
      end
      return code;
   endfunction

endpackage

### hdl/cst_if.sv
// Handshake channels of the C subset token scanner: source bytes in, tokens out.
// Depends on cst_pkg for the field widths.
interface cst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_text;

   modport source (output valid, output char_byte, output end_of_text, input ready);
   modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface cst_rsp_if;
   import cst_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] token_kind;
   logic [CODE_W-1:0] word_code;
   logic [ERR_W-1:0]  error_code;
   logic [SPAN_W-1:0] span_start;
   logic [SPAN_W-1:0] span_end;
   logic [LINE_W-1:0] first_line_no;
   logic [COL_W-1:0]  first_col_no;
   logic [LINE_W-1:0] last_line_no;
   logic [COL_W-1:0]  last_col_no;
   logic              run_last;

   modport source (output valid, output token_kind, output word_code, output error_code,
                   output span_start, output span_end, output first_line_no,
                   output first_col_no, output last_line_no, output last_col_no,
                   output run_last, input ready);
   modport sink   (input valid, input token_kind, input word_code, input error_code,
                   input span_start, input span_end, input first_line_no,
                   input first_col_no, input last_line_no, input last_col_no,
                   input run_last, output ready);
endinterface

### hdl/cst_scan_core.sv
// Scanner state and per-byte token logic of the C subset token scanner.
// Depends on cst_pkg; feeds up to two results per transfer to the result queue.
module cst_scan_core #(
   parameter int OFFSET_BITS = 24,
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        char_byte,
   input  logic              end_of_text,
   output cst_pkg::push_type push
);
   import cst_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_NAME, MODE_STR, MODE_ESC, MODE_DOT1, MODE_DOT2
   } mode_type;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   mode_type               mode_ff, mode_in;
   logic [NAME_W-1:0]      chars_ff, chars_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [OFFSET_BITS-1:0] tb_ff, tb_in, ts_ff, ts_in, byte_ff, byte_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, bl_ff, bl_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in, bc_ff, bc_in;
   logic                   done_ff, done_in;

   logic                   is_alpha, is_alnum, is_space, is_nl, ends, do_start;
   logic [OFFSET_BITS-1:0] after;
   logic [LINE_BITS-1:0]   line_adv;
   logic [COLUMN_BITS-1:0] col_adv, col_end, col_eof;
   logic [CODE_W-1:0]      kw, punct;
   logic [KIND_W-1:0]      pend_kind;
   logic [CODE_W-1:0]      pend_code;
   logic [ERR_W-1:0]       pend_err;
   logic                   pend_v, flush_v, tok_v;
   rsp_type                flush_r, tok_r, first_r, second_r;

   function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [LINE_BITS-1:0] sat_line(input logic [LINE_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [COLUMN_BITS-1:0] sat_col(input logic [COLUMN_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [CODE_W-1:0] punct_code(input logic [7:0] c);
      logic [CODE_W-1:0] code;
      case (c)
         CH_LPAREN: code = CODE_LPAREN;
         CH_RPAREN: code = CODE_RPAREN;
         CH_LBRACE: code = CODE_LBRACE;
         CH_RBRACE: code = CODE_RBRACE;
         CH_STAR:   code = CODE_STAR;
         CH_SEMI:   code = CODE_SEMI;
         CH_COMMA:  code = CODE_COMMA;
         default:   code = CODE_NONE;
      endcase
      return code;
   endfunction

   // The first column is reported one below the stored value, floored at zero.
   function automatic rsp_type make_result(input logic [KIND_W-1:0] kind,
                                           input logic [CODE_W-1:0] code,
                                           input logic [ERR_W-1:0] err,
                                           input logic [OFFSET_BITS-1:0] s,
                                           input logic [OFFSET_BITS-1:0] e,
                                           input logic [LINE_BITS-1:0] fl,
                                           input logic [COLUMN_BITS-1:0] fc,
                                           input logic [LINE_BITS-1:0] ll,
                                           input logic [COLUMN_BITS-1:0] lc);
      rsp_type                r;
      logic [COLUMN_BITS-1:0] fcm;
      fcm             = (fc == '0) ? '0 : fc - 1'b1;
      r.token_kind    = kind;
      r.word_code     = code;
      r.error_code    = err;
      r.span_start    = SPAN_W'(s);
      r.span_end      = SPAN_W'(e);
      r.first_line_no = LINE_W'(fl);
      r.first_col_no  = COL_W'(fcm);
      r.last_line_no  = LINE_W'(ll);
      r.last_col_no   = COL_W'(lc);
      r.run_last      = 1'b0;
      return r;
   endfunction

   assign is_alpha = (char_byte >= "a" && char_byte <= "z") ||
                     (char_byte >= "A" && char_byte <= "Z") || char_byte == "_";
   assign is_alnum = is_alpha || (char_byte >= "0" && char_byte <= "9");
   assign is_nl    = char_byte == CH_NL;
   assign is_space = char_byte == CH_SPACE || char_byte == CH_TAB || is_nl ||
                     char_byte == CH_VT || char_byte == CH_FF;
   assign ends     = end_of_text || char_byte == 8'd0;
   assign after    = sat_off(byte_ff);
   assign line_adv = is_nl ? sat_line(line_ff) : line_ff;
   assign col_adv  = is_nl ? '0 : sat_col(col_ff);
   assign kw       = keyword_code(chars_ff, len_ff);
   assign punct    = punct_code(char_byte);

   // What the open token becomes when something other than its own next byte arrives.
   always_comb begin
      pend_v    = 1'b1;
      pend_kind = KIND_INVALID;
      pend_code = CODE_NONE;
      pend_err  = ERR_NONE;
      case (mode_ff)
         MODE_NAME: begin
            pend_kind = (kw != CODE_NONE) ? KIND_WORD : KIND_IDENT;
            pend_code = kw;
         end
         MODE_DOT1: begin
            pend_kind = KIND_WORD;
            pend_code = CODE_DOT1;
         end
         MODE_DOT2: begin
            pend_kind = KIND_WORD;
            pend_code = CODE_DOT2;
         end
         MODE_STR, MODE_ESC: begin
            pend_err = ERR_UNTERM;
         end
         default: begin
            pend_v = 1'b0;
         end
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      chars_in = chars_ff;
      len_in   = len_ff;
      tb_in    = tb_ff;
      ts_in    = ts_ff;
      byte_in  = byte_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      bl_in    = bl_ff;
      bc_in    = bc_ff;
      done_in  = done_ff;
      flush_v  = 1'b0;
      flush_r  = '0;
      tok_v    = 1'b0;
      tok_r    = '0;
      do_start = 1'b0;
      col_end  = col_ff;
      col_eof  = sat_col(col_ff);
      if (take) begin
         if (done_ff) begin
            col_in = col_eof;
            bl_in  = line_ff;
            bc_in  = col_eof;
            tok_v  = 1'b1;
            tok_r  = make_result(KIND_EOF, CODE_NONE, ERR_NONE, byte_ff, byte_ff,
                                 line_ff, col_eof, line_ff, col_eof);
         end else if (ends) begin
            // A dangling escape swallows the end as one column first.
            col_end = (mode_ff == MODE_ESC) ? sat_col(col_ff) : col_ff;
            col_eof = sat_col(col_end);
            flush_v = pend_v;
            flush_r = make_result(pend_kind, pend_code, pend_err, tb_ff, ts_ff,
                                  bl_ff, bc_ff, line_ff, col_end);
            tok_v   = 1'b1;
            tok_r   = make_result(KIND_EOF, CODE_NONE, ERR_NONE, byte_ff, byte_ff,
                                  line_ff, col_eof, line_ff, col_eof);
            mode_in = MODE_IDLE;
            done_in = 1'b1;
            col_in  = col_eof;
            bl_in   = line_ff;
            bc_in   = col_eof;
         end else begin
            byte_in = after;
            if (char_byte != CH_CR) begin
               case (mode_ff)
                  MODE_NAME: begin
                     if (is_alnum) begin
                        col_in = sat_col(col_ff);
                        ts_in  = after;
                        if (len_ff < LEN_W'(KEYWORD_CHARS)) begin
                           chars_in = {chars_ff[NAME_W-9:0], char_byte};
                           len_in   = len_ff + 1'b1;
                        end else begin
                           len_in = LEN_W'(KEYWORD_CHARS + 1);
                        end
                     end else begin
                        flush_v  = 1'b1;
                        flush_r  = make_result(pend_kind, pend_code, pend_err, tb_ff, ts_ff,
                                               bl_ff, bc_ff, line_ff, col_ff);
                        do_start = 1'b1;
                     end
                  end
                  MODE_STR: begin
                     if (is_nl) begin
                        flush_v  = 1'b1;
                        flush_r  = make_result(KIND_INVALID, CODE_NONE, ERR_NEWLINE, tb_ff,
                                               ts_ff, bl_ff, bc_ff, line_ff, col_ff);
                        do_start = 1'b1;
                     end else begin
                        col_in = sat_col(col_ff);
                        ts_in  = after;
                        if (char_byte == CH_QUOTE) begin
                           tok_v   = 1'b1;
                           tok_r   = make_result(KIND_STRING, CODE_NONE, ERR_NONE, tb_ff,
                                                 after, bl_ff, bc_ff, line_ff,
                                                 sat_col(col_ff));
                           mode_in = MODE_IDLE;
                        end else if (char_byte == CH_BSLASH) begin
                           mode_in = MODE_ESC;
                        end
                     end
                  end
                  MODE_ESC: begin
                     line_in = line_adv;
                     col_in  = col_adv;
                     ts_in   = after;
                     mode_in = MODE_STR;
                  end
                  MODE_DOT1, MODE_DOT2: begin
                     if (char_byte == CH_DOT) begin
                        col_in = sat_col(col_ff);
                        ts_in  = after;
                        if (mode_ff == MODE_DOT1) begin
                           mode_in = MODE_DOT2;
                        end else begin
                           tok_v   = 1'b1;
                           tok_r   = make_result(KIND_WORD, CODE_DOT3, ERR_NONE, tb_ff,
                                                 after, bl_ff, bc_ff, line_ff,
                                                 sat_col(col_ff));
                           mode_in = MODE_IDLE;
                        end
                     end else begin
                        flush_v  = 1'b1;
                        flush_r  = make_result(pend_kind, pend_code, pend_err, tb_ff, ts_ff,
                                               bl_ff, bc_ff, line_ff, col_ff);
                        do_start = 1'b1;
                     end
                  end
                  default: begin
                     do_start = 1'b1;
                  end
               endcase

               // The byte opens a new token, or is whitespace between tokens.
               if (do_start) begin
                  mode_in = MODE_IDLE;
                  line_in = line_adv;
                  col_in  = col_adv;
                  if (!is_space) begin
                     bl_in = line_adv;
                     bc_in = col_adv;
                     tb_in = byte_ff;
                     ts_in = after;
                     if (is_alpha) begin
                        mode_in  = MODE_NAME;
                        chars_in = NAME_W'(char_byte);
                        len_in   = LEN_W'(1);
                     end else if (char_byte == CH_QUOTE) begin
                        mode_in = MODE_STR;
                     end else if (char_byte == CH_DOT) begin
                        mode_in = MODE_DOT1;
                     end else begin
                        tok_v = 1'b1;
                        tok_r = make_result((punct != CODE_NONE) ? KIND_WORD : KIND_INVALID,
                                            punct,
                                            (punct != CODE_NONE) ? ERR_NONE : ERR_UNEXPECTED,
                                            byte_ff, after, line_adv, col_adv,
                                            line_adv, col_adv);
                     end
                  end
               end
            end
         end
      end
   end

   // Pack the results in order; the last one of the transfer carries run_last.
   always_comb begin
      first_r           = flush_v ? flush_r : tok_r;
      first_r.run_last  = !(flush_v && tok_v);
      second_r          = tok_r;
      second_r.run_last = 1'b1;
   end

   assign push.first_valid  = flush_v || tok_v;
   assign push.second_valid = flush_v && tok_v;
   assign push.first        = first_r;
   assign push.second       = second_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         chars_ff <= '0;
         len_ff   <= '0;
         tb_ff    <= '0;
         ts_ff    <= '0;
         byte_ff  <= '0;
         line_ff  <= '0;
         col_ff   <= '0;
         bl_ff    <= '0;
         bc_ff    <= '0;
         done_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         chars_ff <= chars_in;
         len_ff   <= len_in;
         tb_ff    <= tb_in;
         ts_ff    <= ts_in;
         byte_ff  <= byte_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         bl_ff    <= bl_in;
         bc_ff    <= bc_in;
         done_ff  <= done_in;
      end
   end

endmodule

### hdl/cst_result_queue.sv
// Small result queue of the C subset token scanner: takes up to two results
// per cycle, delivers one per transfer. Depends on cst_pkg.
module cst_result_queue (
   input  logic              clock,
   input  logic              reset,
   input  cst_pkg::push_type push,
   output logic              has_room,
   output logic              out_valid,
   input  logic              out_ready,
   output cst_pkg::rsp_type  head
);
   import cst_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rsp_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       push_n;
   logic             pop;

   assign push_n    = {1'b0, push.first_valid} + {1'b0, push.second_valid};
   assign out_valid = count_ff != '0;
   assign pop       = out_valid && out_ready;
   assign head      = entry_ff[rp_ff];
   // Room for the worst case of two results from the next transfer.
   assign has_room  = count_ff <= CNT_W'(QUEUE_DEPTH - 2);

   assign wp_in    = wp_ff + PTR_W'(push_n);
   assign rp_in    = rp_ff + PTR_W'(pop);
   assign count_in = count_ff + CNT_W'(push_n) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[wp_ff] <= push.first;
      end
      if (push.second_valid) begin
         entry_ff[PTR_W'(wp_ff + 1'b1)] <= push.second;
      end
   end

endmodule

### hdl/c_subset_token_scanner_top.sv
// Top level of the C subset token scanner: byte channel in, token channel out.
// Depends on cst_pkg, cst_if, cst_scan_core and cst_result_queue.

// The scanner takes one source byte (or an end marker) per transfer and can take
// a new byte in every clock cycle while the queue has room. All the work for a
// byte happens between the scanner state registers and a four-entry result
// queue, so a token caused by a byte is offered on the result channel in the next
// cycle unless tokens wait ahead of it. One input transfer yields zero, one or two
// tokens; two tokens arise when a byte both closes the open token and forms
// a token of its own, or at end of text when a pending token is flushed ahead of
// the end-of-file token. The result channel delivers one token per transfer, so a
// sustained rate of one byte per cycle holds as long as tokens average at most one
// per byte. The byte channel's ready is high while reset is low and the result
// queue has at least two free entries; it is independent of the scanner mode. Line,
// column and byte offsets saturate at the widths that LINE_BITS, COLUMN_BITS and
// OFFSET_BITS set, and are cut or zero extended to the fixed result field widths.
// After the end marker, every further transfer yields one end-of-file token.
module c_subset_token_scanner_top #(
   parameter int OFFSET_BITS = 24,
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16
) (
   input logic      clock,
   input logic      reset,
   cst_req_if.sink  req_bus,
   cst_rsp_if.source rsp_bus
);
   import cst_pkg::*;

   push_type push;
   rsp_type  head;
   logic     has_room;
   logic     take;

   // A byte transfer happens when the source offers a byte and the queue has room.
   // No byte is taken while reset is high.
   assign req_bus.ready = has_room && !reset;
   assign take          = req_bus.valid && req_bus.ready;

   cst_scan_core #(
      .OFFSET_BITS (OFFSET_BITS),
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .char_byte   (req_bus.char_byte),
      .end_of_text (req_bus.end_of_text),
      .push        (push)
   );

   // The queue separates the two sides, so bytes keep flowing while a token waits.
   cst_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .head      (head)
   );

   assign rsp_bus.token_kind    = head.token_kind;
   assign rsp_bus.word_code     = head.word_code;
   assign rsp_bus.error_code    = head.error_code;
   assign rsp_bus.span_start    = head.span_start;
   assign rsp_bus.span_end      = head.span_end;
   assign rsp_bus.first_line_no = head.first_line_no;
   assign rsp_bus.first_col_no  = head.first_col_no;
   assign rsp_bus.last_line_no  = head.last_line_no;
   assign rsp_bus.last_col_no   = head.last_col_no;
   assign rsp_bus.run_last      = head.run_last;

endmodule

### hdl/cst_port_checker.sv
// Port-level checks of the C subset token scanner, bound to the top level.
// Depends on cst_pkg and c_subset_token_scanner_top_defines.svh.
`include "c_subset_token_scanner_top_defines.svh"

module cst_port_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [cst_pkg::KIND_W-1:0] token_kind,
   input logic [cst_pkg::ERR_W-1:0]  error_code,
   input logic [cst_pkg::SPAN_W-1:0] span_start,
   input logic                      run_last
);
   import cst_pkg::*;

   // A stalled token stays valid with its kind and span start unchanged.
   `CST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(token_kind) && $stable(span_start), "stalled token changed")

   // The end-of-file token is always the last token of its transfer.
   `CST_ASSERT_NOW(a_eof_last, clock, reset, rsp_valid && token_kind == KIND_EOF, run_last, "end-of-file token without run_last")

   // Only invalid tokens carry an error code, and they always do.
   `CST_ASSERT_NOW(a_err_kind, clock, reset, rsp_valid, (token_kind == KIND_INVALID) == (error_code != ERR_NONE), "error code does not match token kind")

   // Back-pressure on bytes only comes from tokens waiting on the result side.
   `CST_ASSERT_NOW(a_stall_cause, clock, reset, !req_ready, rsp_valid, "byte channel stalled with no token waiting")

   // Reset empties the result side.
   `CST_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "token offered right after reset")

endmodule

bind c_subset_token_scanner_top cst_port_checker u_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .token_kind (rsp_bus.token_kind),
   .error_code (rsp_bus.error_code),
   .span_start (rsp_bus.span_start),
   .run_last   (rsp_bus.run_last)
);
